### src/glp_pkg.sv
// Shared types and constants for the granular loop player.
// Used by glp_regs, glp_mul and granular_loop_player_unit.
package glp_pkg;

  localparam int BUF_AW        = 18;
  localparam int BUFFER_DEPTH  = 1 << BUF_AW;
  localparam int WIN_AW        = 12;
  localparam int WINDOW_DEPTH  = 1 << WIN_AW;
  localparam int MAX_GRAINS    = 8;

  // position in 1/256 sample units, kept modulo the buffer
  localparam int POS_W = BUF_AW + 8;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // shared multiplier operand and product widths
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 26;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // floor(x/6) = (x * RECIP6) >> RECIP_SH for 0 <= x < 2^24
  localparam logic [MUL_BW-1:0] RECIP6   = 26'd22369622;
  localparam int                RECIP_SH = 27;

  localparam logic [2:0] REG_RECORD = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_LENGTH = 3'd2;
  localparam logic [2:0] REG_SPREAD = 3'd3;
  localparam logic [2:0] REG_WET    = 3'd4;
  localparam logic [2:0] REG_GAIN   = 3'd5;

  typedef struct packed {
    logic        record_enable;
    logic [3:0]  grain_count;
    logic [12:0] grain_length;
    logic [15:0] grain_spread;
    logic [15:0] wet_mix;
    logic [16:0] grain_gain;
  } cfg_t;

endpackage

### src/glp_regs.sv
// APB-style configuration register file for the granular loop player.
// Depends on glp_pkg for the register layout.
module glp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glp_pkg::PADDR_W-1:0]   paddr,
  input  logic [glp_pkg::PDATA_W-1:0]   pwdata,
  output logic [glp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output glp_pkg::cfg_t                 cfg_o
);
  import glp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_RECORD: cfg_d.record_enable = pwdata[0];
        REG_COUNT:  cfg_d.grain_count   = pwdata[3:0];
        REG_LENGTH: cfg_d.grain_length  = pwdata[12:0];
        REG_SPREAD: cfg_d.grain_spread  = pwdata[15:0];
        REG_WET:    cfg_d.wet_mix       = pwdata[15:0];
        REG_GAIN:   cfg_d.grain_gain    = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RECORD: prdata = {31'd0, cfg_q.record_enable};
      REG_COUNT:  prdata = {28'd0, cfg_q.grain_count};
      REG_LENGTH: prdata = {19'd0, cfg_q.grain_length};
      REG_SPREAD: prdata = {16'd0, cfg_q.grain_spread};
      REG_WET:    prdata = {16'd0, cfg_q.wet_mix};
      REG_GAIN:   prdata = {15'd0, cfg_q.grain_gain};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_enable <= 1'b0;
      cfg_q.grain_count   <= 4'd1;
      cfg_q.grain_length  <= 13'd480;
      cfg_q.grain_spread  <= 16'd77;
      cfg_q.wet_mix       <= 16'd16384;
      cfg_q.grain_gain    <= 17'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/glp_mul.sv
// Shared signed multiplier with a registered product.
// Depends on glp_pkg for operand widths.
module glp_mul (
  input  logic                               clk_i,
  input  logic signed [glp_pkg::MUL_AW-1:0]  a_i,
  input  logic signed [glp_pkg::MUL_BW-1:0]  b_i,
  output logic signed [glp_pkg::MUL_PW-1:0]  p_o
);
  import glp_pkg::*;

  logic signed [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### src/granular_loop_player_unit.sv
// Granular loop player: top level with sequencer, sample and window memories.
// Depends on glp_pkg, glp_regs and glp_mul.
//
// Input channel (in_valid_i / in_stall_o) carries one item per handshake.
// func_i = 0 is an audio item: the dry sample is optionally recorded, up to
// eight grains are read by four-point cubic interpolation, windowed, scaled,
// summed and mixed with the dry sample. One audio_out_o item results.
// func_i = 1 loads one window table entry and restarts the grain position;
// it gives no result, and the unit stays ready for the next item.
// An audio item runs from acceptance to the output register through an
// offset step, for each effective grain the sample reads, multiplications
// and an accumulate, then the mix steps. The single shared multiplier, used
// six times per grain, and the one read port of the sample memory, used four
// times per grain, set its length. in_stall_o is high for the whole item.
// After reset a clearing pass zeroes both memories at every sample address,
// with in_stall_o high. Configuration writes are taken during it.
// The output register holds a result while out_stall_i is high; the next
// item may be accepted meanwhile and waits at its final step until the
// register is free.
module granular_loop_player_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glp_pkg::PADDR_W-1:0]   paddr,
  input  logic [glp_pkg::PDATA_W-1:0]   pwdata,
  output logic [glp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [15:0]            dry_sample_i,
  input  logic signed [15:0]            grain_start_i,
  input  logic [11:0]                   window_index_i,
  input  logic [15:0]                   window_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            audio_out_o
);
  import glp_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_OFF   = 5'd2;
  localparam logic [4:0] S_RD0   = 5'd3;
  localparam logic [4:0] S_RD1   = 5'd4;
  localparam logic [4:0] S_RD2   = 5'd5;
  localparam logic [4:0] S_RD3   = 5'd6;
  localparam logic [4:0] S_RD4   = 5'd7;
  localparam logic [4:0] S_M1    = 5'd8;
  localparam logic [4:0] S_M2    = 5'd9;
  localparam logic [4:0] S_M3    = 5'd10;
  localparam logic [4:0] S_M4    = 5'd11;
  localparam logic [4:0] S_M5    = 5'd12;
  localparam logic [4:0] S_M6    = 5'd13;
  localparam logic [4:0] S_ACC   = 5'd14;
  localparam logic [4:0] S_MIX1  = 5'd15;
  localparam logic [4:0] S_MIX2  = 5'd16;
  localparam logic [4:0] S_MIX3  = 5'd17;

  cfg_t cfg;

  glp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [4:0]          state_q, state_d;
  logic [BUF_AW-1:0]   clr_q;
  logic [BUF_AW-1:0]   wp_q;
  logic [WIN_AW-1:0]   gp_q;
  logic [3:0]          grain_q;
  logic                out_valid_q;
  logic signed [15:0]  out_q;

  logic [POS_W-1:0]    pos_q, off_q;
  logic signed [15:0]  dry_q, a_q, b_q, c_q, d_q;
  logic [15:0]         win_q;
  logic                neg_q;
  logic signed [60:0]  sum_q;
  logic signed [47:0]  mix_q;

  logic                in_acc;
  logic [3:0]          n_eff;
  logic [12:0]         len_eff;
  logic [15:0]         m_eff;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign n_eff   = (cfg.grain_count == 4'd0) ? 4'd1 :
                   (cfg.grain_count > 4'(MAX_GRAINS)) ? 4'(MAX_GRAINS) : cfg.grain_count;
  assign len_eff = (cfg.grain_length > 13'(WINDOW_DEPTH)) ? 13'(WINDOW_DEPTH)
                                                          : cfg.grain_length;
  assign m_eff   = (cfg.wet_mix > 16'd32768) ? 16'd32768 : cfg.wet_mix;

  // sample and window memories
  logic [15:0]        smem [BUFFER_DEPTH];
  logic [15:0]        wmem [WINDOW_DEPTH];
  logic [15:0]        s_rdata_q, w_rdata_q;
  logic               s_we, w_we;
  logic [BUF_AW-1:0]  s_waddr, s_raddr;
  logic [15:0]        s_wdata, w_wdata;
  logic [WIN_AW-1:0]  w_waddr;
  logic [BUF_AW-1:0]  p_base;

  assign p_base = pos_q[POS_W-1:8];

  always_comb begin
    s_we    = 1'b0;
    s_waddr = wp_q;
    s_wdata = dry_sample_i;
    w_we    = 1'b0;
    w_waddr = window_index_i;
    w_wdata = window_value_i;
    if (state_q == S_CLEAR) begin
      s_we    = 1'b1;
      s_waddr = clr_q;
      s_wdata = '0;
      w_we    = (clr_q < BUF_AW'(WINDOW_DEPTH));
      w_waddr = clr_q[WIN_AW-1:0];
      w_wdata = '0;
    end else if (in_acc) begin
      s_we = ~func_i & cfg.record_enable;
      w_we = func_i;
    end
  end

  always_comb begin
    case (state_q)
      S_RD1:   s_raddr = p_base - BUF_AW'(1);
      S_RD2:   s_raddr = p_base - BUF_AW'(2);
      S_RD3:   s_raddr = p_base - BUF_AW'(3);
      default: s_raddr = p_base;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rdata_q <= smem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata_q <= wmem[gp_q];
  end

  // cubic terms
  logic signed [19:0] a20, b20, c20, d20, cmb, e1, e2;
  logic [7:0]         t;
  assign a20 = {{4{a_q[15]}}, a_q};
  assign b20 = {{4{b_q[15]}}, b_q};
  assign c20 = {{4{c_q[15]}}, c_q};
  assign d20 = {{4{d_q[15]}}, d_q};
  assign cmb = c20 - b20;
  assign e1  = d20 - a20 - cmb - cmb - cmb;
  assign e2  = d20 + a20 + a20 - b20 - b20 - b20;
  assign t   = pos_q[7:0];

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;

  glp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  logic signed [MUL_AW-1:0] cmb40, e2_40, lo40;
  logic signed [MUL_PW-1:0] b66, num;
  logic signed [25:0]       q, qmag;
  logic [24:0]              vmag;
  logic signed [25:0]       v;
  logic signed [60:0]       sum_rnd;
  logic signed [28:0]       wet;
  logic signed [47:0]       y_full;
  logic signed [32:0]       y;
  logic signed [15:0]       y_sat;

  assign cmb40   = MUL_AW'(cmb);
  assign e2_40   = MUL_AW'(e2);
  assign lo40    = $signed(prod[MUL_AW-1:0]);
  assign b66     = MUL_PW'(b20);
  // round half up before dividing by 6 * 2^24
  assign num     = prod + (b66 <<< 26) + (b66 <<< 25) + (MUL_PW'(3) <<< 24);
  assign q       = $signed(num[49:24]);
  assign qmag    = q[25] ? (26'sd5 - q) : q;
  assign vmag    = prod[RECIP_SH+24:RECIP_SH];
  assign v       = neg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
  assign sum_rnd = sum_q + (61'sd1 <<< 31);
  assign wet     = sum_rnd[60:32];
  assign y_full  = mix_q + $signed(prod[47:0]) + 48'sd16384;
  assign y       = y_full[47:15];
  assign y_sat   = (y > 33'sd32767) ? 16'sh7fff :
                   (y < -33'sd32768) ? 16'sh8000 : y[15:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        mul_a = $signed({27'd0, len_eff});
        mul_b = $signed({10'd0, cfg.grain_spread});
      end
      S_M1: begin
        mul_a = MUL_AW'(e1);
        mul_b = $signed({18'd0, t});
      end
      S_M2: begin
        mul_a = lo40 + (e2_40 <<< 8);
        mul_b = $signed(MUL_BW'(9'd256 - {1'b0, t}));
      end
      S_M3: begin
        mul_a = (cmb40 <<< 18) + (cmb40 <<< 17) - lo40;
        mul_b = $signed({18'd0, t});
      end
      S_M4: begin
        mul_a = MUL_AW'(qmag);
        mul_b = $signed(RECIP6);
      end
      S_M5: begin
        mul_a = MUL_AW'(v);
        mul_b = $signed({9'd0, cfg.grain_gain});
      end
      S_M6: begin
        mul_a = lo40;
        mul_b = $signed({10'd0, win_q});
      end
      S_MIX1: begin
        mul_a = MUL_AW'(wet);
        mul_b = $signed({10'd0, m_eff});
      end
      // dry term is kept in the product while the result waits
      S_MIX2, S_MIX3: begin
        mul_a = MUL_AW'(dry_q);
        mul_b = $signed(MUL_BW'(17'd32768 - {1'b0, m_eff}));
      end
      default: ;
    endcase
  end

  logic out_hold;
  assign out_hold = out_valid_q & out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (in_acc && !func_i) state_d = S_OFF;
      S_OFF:   state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_RD3;
      S_RD3:   state_d = S_RD4;
      S_RD4:   state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_M3;
      S_M3:    state_d = S_M4;
      S_M4:    state_d = S_M5;
      S_M5:    state_d = S_M6;
      S_M6:    state_d = S_ACC;
      S_ACC:   state_d = (grain_q == n_eff - 4'd1) ? S_MIX1 : S_RD0;
      S_MIX1:  state_d = S_MIX2;
      S_MIX2:  state_d = S_MIX3;
      S_MIX3:  if (!out_hold) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      gp_q        <= '0;
      grain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + BUF_AW'(1);
      if (in_acc && func_i) gp_q <= '0;
      if (state_q == S_OFF) grain_q <= '0;
      if (state_q == S_ACC) grain_q <= grain_q + 4'd1;
      if (state_q == S_MIX3 && !out_hold) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_q + BUF_AW'(1);
        gp_q        <= ({1'b0, gp_q} + 13'd1 >= len_eff) ? '0 : gp_q + WIN_AW'(1);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q <= dry_sample_i;
      pos_q <= (POS_W'({~grain_start_i[15], grain_start_i[14:0]}) << (BUF_AW - 8))
               + POS_W'({gp_q, 8'd0});
    end
    case (state_q)
      S_OFF: begin
        off_q <= prod[POS_W-1:0];
        win_q <= w_rdata_q;
        sum_q <= '0;
      end
      S_RD1: a_q <= s_rdata_q;
      S_RD2: b_q <= s_rdata_q;
      S_RD3: c_q <= s_rdata_q;
      S_RD4: d_q <= s_rdata_q;
      S_M4:  neg_q <= q[25];
      S_ACC: begin
        sum_q <= sum_q + $signed(prod[60:0]);
        pos_q <= pos_q + off_q;
      end
      S_MIX2: mix_q <= $signed(prod[47:0]);
      S_MIX3: if (!out_hold) out_q <= y_sat;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = out_q;

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o)
    else $error("item accepted during memory clear");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_MIX3)
    else $error("result raised outside final mix step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MIX3 && out_hold |=> state_q == S_MIX3 && $stable(out_q))
    else $error("pending result overwritten");

  a_grain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC && grain_q == n_eff - 4'd1 |=> state_q == S_MIX1)
    else $error("grain loop did not end at last grain");

endmodule
